>>> sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by every module of the block and by its checker.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int PRIO_W       = 16;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // One command transaction.
    typedef struct packed {
        logic                     operation;
        logic signed [PRIO_W-1:0] priority_req;
        logic signed [DATA_W-1:0] item_data;
    } spq_in_t;

    // One result transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] removed_data;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
    } spq_out_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic                     valid;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } spq_entry_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } spq_ctl_t;

endpackage

>>> sv/spq_cell.sv
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the entry and control types.
module spq_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::spq_ctl_t ctl,
    input  spq_pkg::spq_entry_t left_entry,
    input  logic              left_le,
    input  spq_pkg::spq_entry_t right_entry,
    output spq_pkg::spq_entry_t entry,
    output logic              le
);

    logic                             valid_reg, valid_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic signed [spq_pkg::DATA_W-1:0] data_reg, data_next;

    // The cell holds an entry that stays ahead of the new one.
    assign le = valid_reg && (prio_reg <= ctl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        if (ctl.ins)
        begin
            if (!le)
            begin
                if (left_le)
                begin
                    valid_next = 1'b1;
                    prio_next  = ctl.prio;
                    data_next  = ctl.data;
                end
                else
                begin
                    valid_next = left_entry.valid;
                    prio_next  = left_entry.prio;
                    data_next  = left_entry.data;
                end
            end
        end
        else if (ctl.rem)
        begin
            valid_next = right_entry.valid;
            prio_next  = right_entry.prio;
            data_next  = right_entry.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign entry.valid = valid_reg;
    assign entry.prio  = prio_reg;
    assign entry.data  = data_reg;

endmodule

>>> sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell instances.
// Depends on spq_pkg and spq_cell.
//
//   channel   ports                     handshake
//   command   start, busy, cmd          taken when start is high and busy is low
//   result    done, result              shown for one cycle while done is high
//
// The whole chain shifts in the cycle a command is taken, and its result is
// registered and shown in the following cycle.
// busy is always low, so a new command may be given in every cycle.
// Reset clears the valid bit of each cell and the entry count; the stored
// priorities and data are not cleared, since an invalid cell is never read.
// The receiver cannot stall the result, so no backpressure path exists.
module sorted_priority_queue
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::spq_in_t  cmd,
    output logic              done,
    output spq_pkg::spq_out_t result
);

    localparam int CW = $clog2(CAPACITY + 1);

    spq_pkg::spq_entry_t entries [CAPACITY];
    logic                le_bits [CAPACITY];
    spq_pkg::spq_ctl_t   ctl;

    logic          accept;
    logic          empty;
    logic          full;
    logic [CW-1:0] count_reg, count_next;

    logic              done_reg;
    spq_pkg::spq_out_t result_reg, result_next;

    // The chain resolves every command in the cycle it is taken, so busy stays low.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Cells stay packed toward the head, so the end cells tell empty and full.
    assign empty = !entries[0].valid;
    assign full  = entries[CAPACITY-1].valid;

    // Refused transactions leave the cells untouched.
    assign ctl.ins  = accept && (cmd.operation == spq_pkg::OP_INSERT) && !full;
    assign ctl.rem  = accept && (cmd.operation == spq_pkg::OP_REMOVE) && !empty;
    assign ctl.prio = cmd.priority_req;
    assign ctl.data = cmd.item_data;

    // Each cell sees its left and right neighbors. The head cell takes a new entry
    // whenever it does not keep its own, and the tail cell shifts in an empty slot.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            spq_pkg::spq_entry_t left_entry;
            spq_pkg::spq_entry_t right_entry;
            logic                left_le;

            if (gi == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_le    = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = entries[gi-1];
                assign left_le    = le_bits[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = entries[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_entry  (left_entry),
                .left_le     (left_le),
                .right_entry (right_entry),
                .entry       (entries[gi]),
                .le          (le_bits[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Build the result of the accepted transaction. The removed data is read
    // from the head cell before the chain shifts.
    always_comb
    begin
        result_next.removed_data = '0;
        result_next.status       = spq_pkg::ST_OK;
        result_next.occupancy    = spq_pkg::OCC_W'(count_next);
        if (cmd.operation == spq_pkg::OP_REMOVE)
        begin
            if (empty)
            begin
                result_next.status = spq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                result_next.removed_data = entries[0].data;
            end
        end
        else if (full)
        begin
            result_next.status = spq_pkg::ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> sv/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to its top level.
// Depends on spq_pkg and on the ports of sorted_priority_queue.
module spq_checker
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input spq_pkg::spq_in_t  cmd,
    input logic              done,
    input spq_pkg::spq_out_t result
);

    // Every accepted transaction produces exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without an accepted transaction");

    // A refused insert only happens with the queue at capacity.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == spq_pkg::ST_FULL) |->
        (result.occupancy == spq_pkg::OCC_W'(CAPACITY)))
        else $error("full status with queue not at capacity");

    // An underflow leaves the queue empty and returns zero data.
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == spq_pkg::ST_UNDERFLOW) |->
        (result.occupancy == '0 && result.removed_data == '0))
        else $error("underflow with entries held or nonzero data");

    // An insert never reports removed data.
    a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.operation == spq_pkg::OP_INSERT) |=>
        (result.removed_data == '0))
        else $error("insert returned nonzero data");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

>>> sim/spq_result_checker.sv
// Result checker for the sorted priority queue: keeps a shadow copy of the queue,
// predicts the outcome of every accepted command and compares each result against it.
// Depends on spq_pkg only; it is instantiated beside the block by the testbench top.
module spq_result_checker
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  spq_pkg::spq_in_t  cmd,
    input  logic              done,
    input  spq_pkg::spq_out_t result,
    output int                errors,
    output int                outstanding,
    output int                underflows,
    output int                refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 60;

    // Shadow copy of the queue, kept in service order.
    logic signed [spq_pkg::PRIO_W-1:0] shadow_prio [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] shadow_data [CAPACITY];
    int                                shadow_count;

    spq_pkg::spq_out_t predicted_outcomes [$];

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t ns: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // Applies one command to the shadow queue and returns the outcome it should produce.
    task automatic shadow_queue_step(input spq_pkg::spq_in_t c,
                                     output spq_pkg::spq_out_t outcome);
        int pos;
        outcome = '0;
        outcome.status = spq_pkg::ST_OK;
        if (c.operation == spq_pkg::OP_REMOVE)
        begin
            if (shadow_count == 0)
                outcome.status = spq_pkg::ST_UNDERFLOW;
            else
            begin
                outcome.removed_data = shadow_data[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_prio[i-1] = shadow_prio[i];
                    shadow_data[i-1] = shadow_data[i];
                end
                shadow_count--;
            end
        end
        else if (shadow_count >= CAPACITY)
            outcome.status = spq_pkg::ST_FULL;
        else
        begin
            // A new entry goes behind every entry of equal or smaller priority number.
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= c.priority_req)
                pos++;
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_prio[i] = shadow_prio[i-1];
                shadow_data[i] = shadow_data[i-1];
            end
            shadow_prio[pos] = c.priority_req;
            shadow_data[pos] = c.item_data;
            shadow_count++;
        end
        outcome.occupancy = shadow_count[spq_pkg::OCC_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        spq_pkg::spq_out_t want;
        spq_pkg::spq_out_t predicted;
        if (!rst_n)
        begin
            shadow_count = 0;
            predicted_outcomes.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (predicted_outcomes.size() == 0)
                    report_mismatch("result with no command pending", '0, result.removed_data);
                else
                begin
                    want = predicted_outcomes.pop_front();
                    if (result.removed_data !== want.removed_data)
                        report_mismatch("removed_data", want.removed_data, result.removed_data);
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(result.status));
                    if (result.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(want.occupancy),
                                        32'(result.occupancy));
                    if (want.status == spq_pkg::ST_UNDERFLOW)
                        underflows++;
                    if (want.status == spq_pkg::ST_FULL)
                        refusals++;
                end
            end
            if (start && !busy)
            begin
                shadow_queue_step(cmd, predicted);
                predicted_outcomes.push_back(predicted);
            end
            outstanding = predicted_outcomes.size();
        end
    end

endmodule

>>> sim/sorted_priority_queue_test.sv
// Testbench top for the sorted priority queue: clock, reset, command stimulus and verdict.
// Depends on spq_pkg, the block sorted_priority_queue and the checker spq_result_checker.
// The checker predicts and compares; this module only drives commands and reports.
module sorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_LIMIT  = 200;
    localparam int CMD_W        = $bits(spq_pkg::spq_in_t);

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    spq_pkg::spq_in_t  cmd;
    logic              done;
    spq_pkg::spq_out_t result;

    int errors;
    int outstanding;
    int underflows;
    int refusals;

    int inserts_sent;
    int removes_sent;
    bit drain_stuck;

    // A 10 ns clock period.
    always #5 clk = ~clk;

    sorted_priority_queue dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    spq_result_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding),
        .underflows  (underflows),
        .refusals    (refusals)
    );

    // Builds an insert command.
    function automatic spq_pkg::spq_in_t insert_cmd(
        input logic signed [spq_pkg::PRIO_W-1:0] prio,
        input logic [spq_pkg::DATA_W-1:0] data);
        spq_pkg::spq_in_t c;
        c.operation    = spq_pkg::OP_INSERT;
        c.priority_req = prio;
        c.item_data    = data;
        return c;
    endfunction

    // Builds a removal. The priority and data fields are ignored by the block, so they
    // carry random values to show that they really are ignored.
    function automatic spq_pkg::spq_in_t remove_cmd();
        spq_pkg::spq_in_t c;
        c.operation    = spq_pkg::OP_REMOVE;
        c.priority_req = spq_pkg::PRIO_W'($urandom_range(0, 65535));
        c.item_data    = $urandom();
        return c;
    endfunction

    // Priority styles: 0 spreads over the whole 16-bit range, 1 crowds into a few values
    // so that ties are common, 2 sticks to the extremes and the values around zero.
    function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority(input int style);
        logic signed [spq_pkg::PRIO_W-1:0] p;
        case (style)
            1:       p = spq_pkg::PRIO_W'($signed($urandom_range(0, 4)) - 2);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       p = 16'sh8000;
                    1:       p = 16'sh7fff;
                    2:       p = 16'sh0000;
                    default: p = 16'shffff;
                endcase
            end
            default: p = spq_pkg::PRIO_W'($urandom_range(0, 65535));
        endcase
        return p;
    endfunction

    // Presents one command and returns at the clock edge on which it is taken. The caller
    // is always at a rising edge here, so start is raised at most once in a time step and
    // a back-to-back command simply keeps it high.
    task automatic send_command(input spq_pkg::spq_in_t c);
        start <= 1'b1;
        cmd   <= c;
        if (c.operation == spq_pkg::OP_REMOVE)
            removes_sent++;
        else
            inserts_sent++;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Leaves the command channel idle for some cycles, with junk on the payload.
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        cmd   <= CMD_W'({$urandom(), $urandom()});
        repeat (cycles) @(posedge clk);
    endtask

    // Stops sending and waits until the checker holds no more predictions. The count is
    // looked at on the falling edge, where it is settled, and the task comes back on a
    // rising edge so that the next command is driven in step with the clock.
    task automatic wait_for_results();
        int waited;
        start  <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
        if (outstanding != 0)
            drain_stuck = 1'b1;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        spq_pkg::spq_in_t directed [$];
        int               segment_left;
        int               insert_pct;
        int               prio_style;
        int               burst_left;
        bit               gaps_on;
        spq_pkg::spq_in_t c;

        inserts_sent = 0;
        removes_sent = 0;
        drain_stuck  = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. It opens with a removal from the empty queue, checks that equal
        // priorities leave in arrival order, uses the extreme priorities and data words,
        // fills the queue to capacity, tries an insert into the full queue and then
        // frees two places and fills them again until the queue refuses once more.
        directed.push_back(remove_cmd());
        directed.push_back(insert_cmd(16'sd5, 32'h1111_1111));
        directed.push_back(insert_cmd(16'sd5, 32'h2222_2222));
        directed.push_back(insert_cmd(16'sh8000, 32'h8000_0000));
        directed.push_back(insert_cmd(16'sh7fff, 32'h7fff_ffff));
        directed.push_back(remove_cmd());
        directed.push_back(insert_cmd(16'sh8000, 32'hffff_ffff));
        for (int i = 0; i < 12; i++)
            directed.push_back(insert_cmd(pick_priority(i % 3), $urandom()));
        directed.push_back(insert_cmd(16'sd0, 32'h0000_0000));
        directed.push_back(remove_cmd());
        directed.push_back(remove_cmd());
        directed.push_back(insert_cmd(16'sh7fff, 32'hdead_beef));
        directed.push_back(insert_cmd(16'sh8000, 32'h0000_0001));
        directed.push_back(insert_cmd(16'sd5, 32'h5555_5555));
        foreach (directed[i])
            send_command(directed[i]);
        wait_for_results();

        // Random part. It runs in segments, each with its own mix of inserts and removals,
        // so the queue keeps swinging between full and empty and both refusals are hit
        // many times. Within a segment commands come in bursts; some segments send with
        // no gaps at all so that back-to-back commands are covered as well.
        segment_left = 0;
        burst_left   = 0;
        insert_pct   = 50;
        prio_style   = 0;
        gaps_on      = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (segment_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                prio_style   = $urandom_range(0, 2);
                gaps_on      = ($urandom_range(0, 3) != 0);
                segment_left = $urandom_range(20, 80);
            end

            // Halfway through, stop and let every outstanding result come back before
            // going on.
            if (k == RANDOM_ITEMS / 2)
                wait_for_results();

            if ($urandom_range(1, 100) <= insert_pct)
                c = insert_cmd(pick_priority(prio_style), $urandom());
            else
                c = remove_cmd();
            send_command(c);
            segment_left--;

            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                if (gaps_on)
                    hold_off($urandom_range(1, 7));
            end
        end

        // Wait for the last results, then a few more cycles to catch anything extra.
        wait_for_results();
        repeat (4) @(posedge clk);

        $display("Run covered %0d commands: %0d inserts and %0d removals.",
                 inserts_sent + removes_sent, inserts_sent, removes_sent);
        $display("Underflow results: %0d, full-queue refusals: %0d, mismatches: %0d.",
                 underflows, refusals, errors);
        if (drain_stuck)
            $display("Some results never arrived.");
        if (errors == 0 && !drain_stuck)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", outstanding);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
sim/spq_result_checker.sv
sim/sorted_priority_queue_test.sv
